@@ src/pfis_pkg.sv @@
// ----------------------------------------------------------------------------
// pfis_pkg
// Shared types and constants for the particle force and integration pipeline.
// ----------------------------------------------------------------------------
package pfis_pkg;

	// Configuration register map, one 32-bit word per register.
	typedef enum logic [2:0] {
		REG_PUSH_X,
		REG_PUSH_Y,
		REG_ATTR_X,
		REG_ATTR_Y,
		REG_ATTR_Z,
		REG_ATTR_S
	} reg_idx_t;

	// Saturation limit of the age field.
	localparam logic [23:0] AGE_MAX = 24'hFFFFFF;

	// Upper limit of the force magnitude quotient (2^47 - 1).
	localparam logic [46:0] M_LIMIT = '1;

	// Reciprocal of 1000 scaled by 2^57 and rounded up. Multiplying a value
	// below 2^47 by it and dropping 57 bits gives the exact quotient by 1000.
	localparam logic [47:0] MS_RECIP = 48'h8312_6E97_8D50;

	// Square root radicand and root widths.
	localparam int unsigned RAD_W  = 66;
	localparam int unsigned ROOT_W = 33;

	// Fields that travel with a particle through the whole pipeline.
	typedef struct packed {
		logic               alive;
		logic [15:0]        step;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx0;
		logic signed [31:0] vy0;
		logic signed [31:0] vx1;
		logic signed [31:0] vy1;
		logic [23:0]        age;
		logic               sneg;
		logic [31:0]        smag;
	} base_t;

	// Sideband through the square root.
	typedef struct packed {
		base_t       base;
		logic [32:0] ax;
		logic [32:0] ay;
		logic        sx;
		logic        sy;
		logic        nz;
	} sqrt_pay_t;

	// Sideband through the unit direction divider.
	typedef struct packed {
		base_t base;
		logic  sx;
		logic  sy;
		logic  nz;
	} udiv_pay_t;

	// Sideband through the force magnitude divider.
	typedef struct packed {
		base_t              base;
		logic signed [17:0] ux;
		logic signed [17:0] uy;
		logic               rbig;
		logic               ovf;
		logic               nz;
	} qdiv_pay_t;

	// Sideband through the millisecond scaling.
	typedef struct packed {
		base_t              base;
		logic signed [31:0] vx2;
		logic signed [31:0] vy2;
		logic               nx;
		logic               ny;
	} pdiv_pay_t;

endpackage

@@ src/particle_force_integrate_step.sv @@
// ----------------------------------------------------------------------------
// particle_force_integrate_step
// Throughput: one particle per cycle while the output beat is not stalled; the
// square root and the two dividers are fully pipelined, one bit per stage, and
// the scaling by 1000 is a reciprocal multiplication over three stages.
// A stalled output beat freezes the whole pipeline and holds the input stalled.
// Reset clears the valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module particle_force_integrate_step (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        step_ms,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [23:0]        age_ms,
	input  logic [23:0]        life_ms,
	// Output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               alive,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic [23:0]        new_age_ms
);
	import pfis_pkg::*;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [31:0] push_x_q, push_y_q, attr_x_q, attr_y_q, attr_z_q, attr_s_q;
	reg_idx_t           cfg_sel;
	logic               cfg_wr;

	assign cfg_sel = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_x_q <= '0;
			push_y_q <= '0;
			attr_x_q <= '0;
			attr_y_q <= '0;
			attr_z_q <= '0;
			attr_s_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_PUSH_X: push_x_q <= pwdata;
				REG_PUSH_Y: push_y_q <= pwdata;
				REG_ATTR_X: attr_x_q <= pwdata;
				REG_ATTR_Y: attr_y_q <= pwdata;
				REG_ATTR_Z: attr_z_q <= pwdata;
				REG_ATTR_S: attr_s_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (cfg_sel)
			REG_PUSH_X: prdata = push_x_q;
			REG_PUSH_Y: prdata = push_y_q;
			REG_ATTR_X: prdata = attr_x_q;
			REG_ATTR_Y: prdata = attr_y_q;
			REG_ATTR_Z: prdata = attr_z_q;
			REG_ATTR_S: prdata = attr_s_q;
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control: everything advances unless the output beat stalls.
	// ------------------------------------------------------------------
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s55;
	logic v_s103, v_s104, v_s105, v_s106, v_s107, v_s108;
	logic v_s109, v_s110, v_s111, v_s112, v_s113;

	assign en       = !(v_s113 && out_stall);
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// Stage 1: expiry test, age update, push force, offsets to attractor.
	// ------------------------------------------------------------------
	base_t              b_c;
	logic signed [32:0] vx_sum, vy_sum;
	logic [24:0]        age_sum;
	base_t              b_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;

	always_comb begin
		vx_sum  = {vel_x[31], vel_x} + {push_x_q[31], push_x_q};
		vy_sum  = {vel_y[31], vel_y} + {push_y_q[31], push_y_q};
		age_sum = {1'b0, age_ms} + {9'd0, step_ms};
		b_c.alive = age_ms < life_ms;
		b_c.step  = step_ms;
		b_c.px    = pos_x;
		b_c.py    = pos_y;
		b_c.vx0   = vel_x;
		b_c.vy0   = vel_y;
		b_c.vx1   = sat32(64'(vx_sum));
		b_c.vy1   = sat32(64'(vy_sum));
		if (!b_c.alive) begin
			b_c.age = age_ms;
		end else if (age_sum[24]) begin
			b_c.age = AGE_MAX;
		end else begin
			b_c.age = age_sum[23:0];
		end
		b_c.sneg = attr_s_q[31];
		b_c.smag = attr_s_q[31] ? (~attr_s_q + 32'd1) : attr_s_q;
	end

	// ------------------------------------------------------------------
	// Stages 2 to 4: magnitudes, squares, squared distance.
	// ------------------------------------------------------------------
	base_t       b_s2, b_s3;
	logic [32:0] ax_s2, ay_s2, az_s2, ax_s3, ay_s3;
	logic        sx_s2, sy_s2, sx_s3, sy_s3, nz_s3;
	logic [65:0] a2_s3, b2_s3, c2_s3;
	sqrt_pay_t   sp_s4;
	logic [65:0] ss_s4;

	// ------------------------------------------------------------------
	// Square root and unit direction divider.
	// ------------------------------------------------------------------
	logic                   sq_v;
	logic [ROOT_W-1:0]      sq_root;
	logic [$bits(sqrt_pay_t)-1:0] sq_pay_w;
	sqrt_pay_t              sq_p;

	logic [1:0][48:0]       ud_num;
	udiv_pay_t              ud_in;
	logic                   ud_v;
	logic [1:0][16:0]       ud_q;
	logic [$bits(udiv_pay_t)-1:0] ud_pay_w;
	udiv_pay_t              ud_p;

	pfis_sqrt #(
		.PW($bits(sqrt_pay_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.rad      (ss_s4),
		.in_pay   (sp_s4),
		.out_valid(sq_v),
		.root     (sq_root),
		.out_pay  (sq_pay_w)
	);

	assign sq_p      = sq_pay_w;
	assign ud_num[0] = {sq_p.ax, 16'd0};
	assign ud_num[1] = {sq_p.ay, 16'd0};

	always_comb begin
		ud_in.base = sq_p.base;
		ud_in.sx   = sq_p.sx;
		ud_in.sy   = sq_p.sy;
		ud_in.nz   = sq_p.nz;
	end

	// The root rides along as the divisor and is read back from the last stage.
	logic [ROOT_W-1:0] ud_root;

	pfis_div #(
		.LANES(2),
		.NW   (49),
		.DW   (ROOT_W),
		.QW   (17),
		.PW   ($bits(udiv_pay_t) + ROOT_W)
	) u_udiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_v),
		.num      (ud_num),
		.den      (sq_root),
		.in_pay   ({ud_in, sq_root}),
		.out_valid(ud_v),
		.quo      (ud_q),
		.out_pay  ({ud_pay_w, ud_root})
	);

	assign ud_p = ud_pay_w;

	// ------------------------------------------------------------------
	// Stage 55: signed unit direction and squared root.
	// ------------------------------------------------------------------
	base_t              b_s55;
	logic signed [17:0] ux_s55, uy_s55;
	logic               rbig_s55, nz_s55;
	logic [63:0]        rr_s55;
	logic [0:0][63:0]   qd_num;
	qdiv_pay_t          qd_in;
	logic               qd_v;
	logic [0:0][46:0]   qd_q;
	logic [$bits(qdiv_pay_t)-1:0] qd_pay_w;
	qdiv_pay_t          qd_p;

	assign qd_num[0] = {b_s55.smag, 32'd0};

	always_comb begin
		qd_in.base = b_s55;
		qd_in.ux   = ux_s55;
		qd_in.uy   = uy_s55;
		qd_in.rbig = rbig_s55;
		qd_in.ovf  = 64'(b_s55.smag[31:15]) >= rr_s55;
		qd_in.nz   = nz_s55;
	end

	pfis_div #(
		.LANES(1),
		.NW   (64),
		.DW   (64),
		.QW   (47),
		.PW   ($bits(qdiv_pay_t))
	) u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s55),
		.num      (qd_num),
		.den      (rr_s55),
		.in_pay   (qd_in),
		.out_valid(qd_v),
		.quo      (qd_q),
		.out_pay  (qd_pay_w)
	);

	assign qd_p = qd_pay_w;

	// ------------------------------------------------------------------
	// Stages 103 to 108: force, velocity, displacement products.
	// ------------------------------------------------------------------
	logic [46:0]        mq_c;
	base_t              b_s103, b_s104, b_s105, b_s106, b_s107;
	logic signed [47:0] m_s103;
	logic signed [17:0] ux_s103, uy_s103;
	logic signed [65:0] fpx_s104, fpy_s104;
	logic signed [65:0] fbx_c, fby_c;
	logic signed [49:0] fx_s105, fy_s105;
	logic signed [31:0] vx2_s106, vy2_s106, vx2_s107, vy2_s107;
	logic signed [48:0] prx_s107, pry_s107;
	pdiv_pay_t          pd_s108;
	logic [1:0][46:0]   pm_s108;

	always_comb begin
		if (qd_p.rbig || !qd_p.nz) begin
			mq_c = '0;
		end else if (qd_p.ovf) begin
			mq_c = M_LIMIT;
		end else begin
			mq_c = qd_q[0];
		end
		fbx_c = fpx_s104 + (fpx_s104[65] ? 66'sd65535 : 66'sd0);
		fby_c = fpy_s104 + (fpy_s104[65] ? 66'sd65535 : 66'sd0);
	end

	// ------------------------------------------------------------------
	// Stages 109 to 111: division by 1000 as a multiplication by its
	// reciprocal, split into 24-bit partial products.
	// Stages 112 and 113: signed displacement and output.
	// ------------------------------------------------------------------
	pdiv_pay_t          pd_s109, pd_s110, pd_s111;
	logic [1:0][47:0]   pll_s109, plh_s109, phl_s109, phh_s109;
	logic [1:0][47:0]   pll_s110, phh_s110;
	logic [1:0][48:0]   pmid_s110;
	logic [1:0][95:0]   prod_c;
	logic [1:0][37:0]   pq_s111;
	base_t              b_s112;
	logic signed [31:0] vx2_s112, vy2_s112;
	logic signed [38:0] dqx_s112, dqy_s112;
	logic               alive_s113;
	logic signed [31:0] npx_s113, npy_s113, nvx_s113, nvy_s113;
	logic [23:0]        nage_s113;

	// The outer partial products do not overlap, so one addition remains.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			prod_c[l] = {phh_s110[l], pll_s110[l]} + {23'd0, pmid_s110[l], 24'd0};
		end
	end

	// ------------------------------------------------------------------
	// Valid bits of the local stages.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s55  <= 1'b0;
			v_s103 <= 1'b0;
			v_s104 <= 1'b0;
			v_s105 <= 1'b0;
			v_s106 <= 1'b0;
			v_s107 <= 1'b0;
			v_s108 <= 1'b0;
			v_s109 <= 1'b0;
			v_s110 <= 1'b0;
			v_s111 <= 1'b0;
			v_s112 <= 1'b0;
			v_s113 <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s55  <= ud_v;
			v_s103 <= qd_v;
			v_s104 <= v_s103;
			v_s105 <= v_s104;
			v_s106 <= v_s105;
			v_s107 <= v_s106;
			v_s108 <= v_s107;
			v_s109 <= v_s108;
			v_s110 <= v_s109;
			v_s111 <= v_s110;
			v_s112 <= v_s111;
			v_s113 <= v_s112;
		end
	end

	// ------------------------------------------------------------------
	// Data registers of the local stages.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1
			b_s1  <= b_c;
			dx_s1 <= {pos_x[31], pos_x} - {attr_x_q[31], attr_x_q};
			dy_s1 <= {pos_y[31], pos_y} - {attr_y_q[31], attr_y_q};
			dz_s1 <= {pos_z[31], pos_z} - {attr_z_q[31], attr_z_q};
			// Stage 2
			b_s2  <= b_s1;
			ax_s2 <= dx_s1[32] ? 33'(-dx_s1) : dx_s1;
			ay_s2 <= dy_s1[32] ? 33'(-dy_s1) : dy_s1;
			az_s2 <= dz_s1[32] ? 33'(-dz_s1) : dz_s1;
			sx_s2 <= dx_s1[32];
			sy_s2 <= dy_s1[32];
			// Stage 3
			b_s3  <= b_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			nz_s3 <= |{ax_s2, ay_s2, az_s2};
			a2_s3 <= ax_s2 * ax_s2;
			b2_s3 <= ay_s2 * ay_s2;
			c2_s3 <= az_s2 * az_s2;
			// Stage 4
			sp_s4.base <= b_s3;
			sp_s4.ax   <= ax_s3;
			sp_s4.ay   <= ay_s3;
			sp_s4.sx   <= sx_s3;
			sp_s4.sy   <= sy_s3;
			sp_s4.nz   <= nz_s3;
			ss_s4      <= a2_s3 + b2_s3 + c2_s3;
			// Stage 55
			b_s55    <= ud_p.base;
			ux_s55   <= ud_p.sx ? -$signed({1'b0, ud_q[0]}) : $signed({1'b0, ud_q[0]});
			uy_s55   <= ud_p.sy ? -$signed({1'b0, ud_q[1]}) : $signed({1'b0, ud_q[1]});
			rbig_s55 <= ud_root[ROOT_W-1];
			nz_s55   <= ud_p.nz;
			rr_s55   <= ud_root[31:0] * ud_root[31:0];
			// Stage 103: signed force magnitude
			b_s103  <= qd_p.base;
			ux_s103 <= qd_p.ux;
			uy_s103 <= qd_p.uy;
			m_s103  <= qd_p.base.sneg ? -$signed({1'b0, mq_c}) : $signed({1'b0, mq_c});
			// Stage 104: direction times magnitude
			b_s104   <= b_s103;
			fpx_s104 <= ux_s103 * m_s103;
			fpy_s104 <= uy_s103 * m_s103;
			// Stage 105: divide by 65536 toward zero
			b_s105  <= b_s104;
			fx_s105 <= fbx_c[65:16];
			fy_s105 <= fby_c[65:16];
			// Stage 106: add point force to velocity
			b_s106   <= b_s105;
			vx2_s106 <= sat32(64'(b_s105.vx1) + 64'(fx_s105));
			vy2_s106 <= sat32(64'(b_s105.vy1) + 64'(fy_s105));
			// Stage 107: velocity times step
			b_s107   <= b_s106;
			vx2_s107 <= vx2_s106;
			vy2_s107 <= vy2_s106;
			prx_s107 <= vx2_s106 * $signed({1'b0, b_s106.step});
			pry_s107 <= vy2_s106 * $signed({1'b0, b_s106.step});
			// Stage 108: sign and magnitude for the scaling
			pd_s108.base <= b_s107;
			pd_s108.vx2  <= vx2_s107;
			pd_s108.vy2  <= vy2_s107;
			pd_s108.nx   <= prx_s107[48];
			pd_s108.ny   <= pry_s107[48];
			pm_s108[0]   <= prx_s107[48] ? 47'(-prx_s107) : prx_s107[46:0];
			pm_s108[1]   <= pry_s107[48] ? 47'(-pry_s107) : pry_s107[46:0];
			// Stage 109: partial products with the reciprocal
			pd_s109 <= pd_s108;
			for (int l = 0; l < 2; l++) begin
				pll_s109[l] <= pm_s108[l][23:0] * MS_RECIP[23:0];
				plh_s109[l] <= pm_s108[l][23:0] * MS_RECIP[47:24];
				phl_s109[l] <= pm_s108[l][46:24] * MS_RECIP[23:0];
				phh_s109[l] <= pm_s108[l][46:24] * MS_RECIP[47:24];
			end
			// Stage 110: middle partial products summed
			pd_s110 <= pd_s109;
			for (int l = 0; l < 2; l++) begin
				pll_s110[l]  <= pll_s109[l];
				phh_s110[l]  <= phh_s109[l];
				pmid_s110[l] <= 49'(plh_s109[l]) + 49'(phl_s109[l]);
			end
			// Stage 111: quotient magnitude, product shifted down by 57
			pd_s111 <= pd_s110;
			for (int l = 0; l < 2; l++) begin
				pq_s111[l] <= prod_c[l][94:57];
			end
			// Stage 112: signed displacement
			b_s112   <= pd_s111.base;
			vx2_s112 <= pd_s111.vx2;
			vy2_s112 <= pd_s111.vy2;
			dqx_s112 <= pd_s111.nx ? -$signed({1'b0, pq_s111[0]}) : $signed({1'b0, pq_s111[0]});
			dqy_s112 <= pd_s111.ny ? -$signed({1'b0, pq_s111[1]}) : $signed({1'b0, pq_s111[1]});
			// Stage 113: new position, expired particles pass unchanged
			alive_s113 <= b_s112.alive;
			nage_s113  <= b_s112.age;
			if (b_s112.alive) begin
				npx_s113 <= sat32(64'(b_s112.px) + 64'(dqx_s112));
				npy_s113 <= sat32(64'(b_s112.py) + 64'(dqy_s112));
				nvx_s113 <= vx2_s112;
				nvy_s113 <= vy2_s112;
			end else begin
				npx_s113 <= b_s112.px;
				npy_s113 <= b_s112.py;
				nvx_s113 <= b_s112.vx0;
				nvy_s113 <= b_s112.vy0;
			end
		end
	end

	assign out_valid  = v_s113;
	assign alive      = alive_s113;
	assign new_pos_x  = npx_s113;
	assign new_pos_y  = npy_s113;
	assign new_vel_x  = nvx_s113;
	assign new_vel_y  = nvy_s113;
	assign new_age_ms = nage_s113;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// A held result beat must block new input beats.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input accepted while result beat is stalled");

	// A nonzero squared distance must give a nonzero root.
	a_root_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s55 && nz_s55) |-> (rbig_s55 || rr_s55 != 64'd0))
		else $error("zero root for nonzero distance");

	// Unit direction components never exceed one in unsigned Q1.16.
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ud_v && ud_p.nz) |-> (ud_q[0] <= 17'd65536 && ud_q[1] <= 17'd65536))
		else $error("unit direction out of range");

endmodule

@@ src/pfis_sqrt.sv @@
// ----------------------------------------------------------------------------
// pfis_sqrt
// Pipelined floor square root, one result bit per stage, with a sideband
// payload that moves alongside each beat.
// ----------------------------------------------------------------------------
module pfis_sqrt #(
	parameter int unsigned PW = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [pfis_pkg::RAD_W-1:0]  rad,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_valid,
	output logic [pfis_pkg::ROOT_W-1:0] root,
	output logic [PW-1:0]               out_pay
);
	import pfis_pkg::*;

	localparam int unsigned NST   = ROOT_W;
	localparam int unsigned REM_W = ROOT_W + 2;

	logic              vld_s  [NST];
	logic [REM_W-1:0]  rem_s  [NST];
	logic [ROOT_W-1:0] root_s [NST];
	logic [RAD_W-1:0]  rad_s  [NST];
	logic [PW-1:0]     pay_s  [NST];

	// One stage per root bit: bring down two radicand bits and try the next bit.
	for (genvar k = 0; k < NST; k++) begin : g_st
		logic              v_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		logic [PW-1:0]     pay_in;
		logic [REM_W+1:0]  rem2;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign pay_in  = in_pay;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign pay_in  = pay_s[k-1];
		end

		assign rem2  = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				pay_s[k]  <= pay_in;
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign root      = root_s[NST-1];
	assign out_pay   = pay_s[NST-1];

endmodule

@@ src/pfis_div.sv @@
// ----------------------------------------------------------------------------
// pfis_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The numerator shifted right by QW must be below the
// divisor.
// ----------------------------------------------------------------------------
module pfis_div #(
	parameter int unsigned LANES = 2,
	parameter int unsigned NW    = 49,
	parameter int unsigned DW    = 33,
	parameter int unsigned QW    = 17,
	parameter int unsigned PW    = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [LANES-1:0][NW-1:0]   num,
	input  logic [DW-1:0]              den,
	input  logic [PW-1:0]              in_pay,
	output logic                       out_valid,
	output logic [LANES-1:0][QW-1:0]   quo,
	output logic [PW-1:0]              out_pay
);

	localparam int unsigned WW = DW + QW;

	// One restoring step: remainder in the upper bits, quotient shifts in below.
	function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
		input logic [DW-1:0] d);
		logic [DW:0] t;
		logic        ge;
		logic [DW:0] r;
		t  = w[WW-1:QW-1];
		ge = t >= {1'b0, d};
		r  = ge ? t - {1'b0, d} : t;
		return {r[DW-1:0], w[QW-2:0], ge};
	endfunction

	logic                      vld_s  [QW];
	logic [LANES-1:0][WW-1:0]  work_s [QW];
	logic [DW-1:0]             den_s  [QW];
	logic [PW-1:0]             pay_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic                     v_in;
		logic [LANES-1:0][WW-1:0] w_in;
		logic [DW-1:0]            d_in;
		logic [PW-1:0]            p_in;

		if (k == 0) begin : g_first
			// Upper numerator bits form the first partial remainder.
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					w_in[l] = {DW'(num[l][NW-1:QW]), num[l][QW-1:0]};
				end
			end
			assign v_in = in_valid;
			assign d_in = den;
			assign p_in = in_pay;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign w_in = work_s[k-1];
			assign d_in = den_s[k-1];
			assign p_in = pay_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					work_s[k][l] <= div_step(w_in[l], d_in);
				end
				den_s[k] <= d_in;
				pay_s[k] <= p_in;
			end
		end
	end

	// Quotient sits in the low bits after the last step.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = work_s[QW-1][l][QW-1:0];
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_pay   = pay_s[QW-1];

endmodule
